/* rtl/assert_macros.svh */
// Assertion macros used by the classifier controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/fmpc_pkg.sv */
// Package with types, codes and constants of the first-match packet classifier.
`default_nettype none

package fmpc_pkg;

  localparam int MAX_RULES_DEF = 64;
  localparam int RULE_COUNT_W  = 7;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_TDATA_W    = 176;
  localparam int OUT_TDATA_W   = 16;
  localparam int RULE_NUM_W    = 6;

  localparam logic [31:0] LOOP_MASK   = 32'hFF00_0000;
  localparam logic [31:0] LOOP_NET    = 32'h7F00_0000;
  localparam logic [15:0] PORT_HIGH   = 16'd1023;
  localparam logic [31:0] INNER_RESET = 32'd167837955;
  localparam logic [31:0] OUTER_RESET = 32'd167838211;

  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  localparam logic [1:0] SEL_SOURCE = 2'd0;
  localparam logic [1:0] SEL_DEST   = 2'd1;
  localparam logic [1:0] SEL_MISC   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_RULE_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_VALID = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INNER_IP    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTER_IP    = 2'd3;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_ANY  = 2'd3;

  localparam logic [1:0] PROTO_ICMP  = 2'd0;
  localparam logic [1:0] PROTO_UDP   = 2'd2;
  localparam logic [1:0] PROTO_OTHER = 2'd3;

  localparam logic [1:0] ACK_NO  = 2'd1;
  localparam logic [1:0] ACK_YES = 2'd2;
  localparam logic [1:0] ACK_ANY = 2'd3;

  typedef enum logic [2:0] {
    REASON_MATCH    = 3'd0,
    REASON_NO_MATCH = 3'd1,
    REASON_INACTIVE = 3'd2,
    REASON_XMAS     = 3'd3,
    REASON_SPECIAL  = 3'd4
  } reason_t;

  typedef enum logic [1:0] {
    RES_PRE  = 2'd0,
    RES_HIT  = 2'd1,
    RES_MISS = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic        pad;
    logic        want_log;
    logic        xmas_flag;
    logic        ack_flag;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [1:0]  proto_code;
    logic [31:0] dest_ip;
    logic [31:0] source_ip;
    logic [1:0]  direction;
    logic [63:0] word_data;
    logic [7:0]  word_address;
  } in_data_t;

  typedef struct packed {
    logic [4:0]            pad;
    logic                  log_request;
    logic [RULE_NUM_W-1:0] matched_rule;
    reason_t               reason;
    logic                  verdict;
  } out_data_t;

  typedef struct packed {
    logic [1:0]  spare;
    logic        action;
    logic [1:0]  ack;
    logic [1:0]  dir;
    logic [2:0]  proto;
    logic [15:0] dport;
    logic [15:0] sport;
  } rule_misc_t;

  typedef struct packed {
    logic     write_rule;
    logic     capture;
    logic     scan_clear;
    logic     scan_step;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic decided;
    logic count_zero;
    logic hit;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* rtl/fmpc_ctrl.sv */
// Controller state machine that sequences writes, checks and the rule scan.
`default_nettype none

`include "assert_macros.svh"

module fmpc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_func,
  output logic                 in_ready,
  input  wire fmpc_pkg::status_t status,
  output fmpc_pkg::cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_FETCH = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_sel = fmpc_pkg::RES_PRE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == fmpc_pkg::FUNC_WRITE) begin
            cmd.write_rule = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (status.decided) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = fmpc_pkg::RES_PRE;
          state_next   = S_DONE;
        end else if (status.count_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = fmpc_pkg::RES_MISS;
          state_next   = S_DONE;
        end else begin
          cmd.scan_clear = 1'b1;
          state_next     = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.scan_step = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = fmpc_pkg::RES_HIT;
          state_next   = S_DONE;
        end else if (status.scan_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = fmpc_pkg::RES_MISS;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_IMPLIES(a_out_load_free, clk, rst, cmd.out_load, status.out_free)
  `ASSERT_NEXT(a_hit_ends_scan, clk, rst, (state == S_SCAN) && status.hit, state == S_DONE)
  `ASSERT_NEXT(a_write_stays_idle, clk, rst, cmd.write_rule, state == S_IDLE)

endmodule

`default_nettype wire

/* rtl/fmpc_datapath.sv */
// Datapath with rule memories, configuration, packet registers, matcher and output register.
`default_nettype none

module fmpc_datapath #(
  parameter int MAX_RULES = fmpc_pkg::MAX_RULES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [fmpc_pkg::IN_TDATA_W-1:0]       in_data,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [fmpc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [fmpc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [fmpc_pkg::OUT_TDATA_W-1:0]           out_data,
  input  wire fmpc_pkg::cmd_t                        cmd,
  output fmpc_pkg::status_t                          status
);

  localparam int IdxW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CntRaw = $clog2(MAX_RULES + 1);
  localparam int CmpW   = (CntRaw > fmpc_pkg::RULE_COUNT_W) ? CntRaw : fmpc_pkg::RULE_COUNT_W;
  localparam logic [CmpW-1:0] MaxCnt = CmpW'(MAX_RULES);

  fmpc_pkg::in_data_t din;
  fmpc_pkg::in_data_t pkt;

  logic [fmpc_pkg::RULE_COUNT_W-1:0] rule_count;
  logic                              table_valid;
  logic [31:0]                       inner_leg_ip;
  logic [31:0]                       outer_leg_ip;

  logic [63:0]              src_mem [MAX_RULES];
  logic [63:0]              dst_mem [MAX_RULES];
  fmpc_pkg::rule_misc_t     misc_mem [MAX_RULES];
  logic [63:0]              src_rd;
  logic [63:0]              dst_rd;
  fmpc_pkg::rule_misc_t     misc_rd;

  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] wr_idx;
  logic            wr_in_range;

  logic [CmpW-1:0] count_ext;
  logic [CmpW-1:0] scan_n;

  logic                  special;
  logic                  pre_verdict;
  fmpc_pkg::reason_t     pre_reason;
  logic                  pre_log;

  logic sip_ok, dip_ok, dir_ok, proto_ok, sport_ok, dport_ok, ack_ok;
  logic [1:0] pkt_ack_code;

  logic                            res_verdict;
  fmpc_pkg::reason_t               res_reason;
  logic [fmpc_pkg::RULE_NUM_W-1:0] res_rule;
  logic                            res_log;
  fmpc_pkg::out_data_t             out_pack;

  assign din       = fmpc_pkg::in_data_t'(in_data);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count   <= '0;
      table_valid  <= 1'b0;
      inner_leg_ip <= fmpc_pkg::INNER_RESET;
      outer_leg_ip <= fmpc_pkg::OUTER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fmpc_pkg::CFG_RULE_COUNT:  rule_count   <= cfg_data[fmpc_pkg::RULE_COUNT_W-1:0];
        fmpc_pkg::CFG_TABLE_VALID: table_valid  <= cfg_data[0];
        fmpc_pkg::CFG_INNER_IP:    inner_leg_ip <= cfg_data;
        fmpc_pkg::CFG_OUTER_IP:    outer_leg_ip <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Rule memories: one write port from the input stream, one registered read port for the scan.
  assign wr_idx      = IdxW'(din.word_address[7:2]);
  assign wr_in_range = CmpW'(din.word_address[7:2]) < MaxCnt;

  always_ff @(posedge clk) begin
    if (cmd.write_rule && wr_in_range) begin
      case (din.word_address[1:0])
        fmpc_pkg::SEL_SOURCE: src_mem[wr_idx]  <= din.word_data;
        fmpc_pkg::SEL_DEST:   dst_mem[wr_idx]  <= din.word_data;
        fmpc_pkg::SEL_MISC:   misc_mem[wr_idx] <= fmpc_pkg::rule_misc_t'(din.word_data[41:0]);
        default: begin
        end
      endcase
    end
    src_rd  <= src_mem[idx];
    dst_rd  <= dst_mem[idx];
    misc_rd <= misc_mem[idx];
    idx_q   <= idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
    end
    if (cmd.capture) begin
      pkt <= din;
    end
  end

  // Scan length and end of scan.
  assign count_ext         = CmpW'(rule_count);
  assign scan_n            = (count_ext > MaxCnt) ? MaxCnt : count_ext;
  assign status.count_zero = (scan_n == '0);
  assign status.scan_last  = (CmpW'(idx_q) == scan_n - 1'b1);

  // Checks that decide before the table is consulted.
  assign special = ((pkt.source_ip & fmpc_pkg::LOOP_MASK) == fmpc_pkg::LOOP_NET) ||
                   ((pkt.dest_ip & fmpc_pkg::LOOP_MASK) == fmpc_pkg::LOOP_NET) ||
                   (pkt.proto_code == fmpc_pkg::PROTO_OTHER) ||
                   (pkt.dest_ip == inner_leg_ip) ||
                   (pkt.source_ip == outer_leg_ip) ||
                   (pkt.direction == fmpc_pkg::DIR_NONE);

  assign status.decided = special || pkt.xmas_flag || !table_valid;

  always_comb begin
    if (special) begin
      pre_verdict = 1'b1;
      pre_reason  = fmpc_pkg::REASON_SPECIAL;
      pre_log     = 1'b0;
    end else if (pkt.xmas_flag) begin
      pre_verdict = 1'b0;
      pre_reason  = fmpc_pkg::REASON_XMAS;
      pre_log     = 1'b1;
    end else begin
      pre_verdict = 1'b1;
      pre_reason  = fmpc_pkg::REASON_INACTIVE;
      pre_log     = pkt.want_log;
    end
  end

  // Rule matcher on the registered memory outputs.
  assign sip_ok = (src_rd[31:0] == '0) ||
                  ((src_rd[31:0] & src_rd[63:32]) == (pkt.source_ip & src_rd[63:32]));
  assign dip_ok = (dst_rd[31:0] == '0) ||
                  ((dst_rd[31:0] & dst_rd[63:32]) == (pkt.dest_ip & dst_rd[63:32]));
  assign dir_ok = (misc_rd.dir == fmpc_pkg::DIR_ANY) || (misc_rd.dir == pkt.direction);
  assign proto_ok = misc_rd.proto[2] || (misc_rd.proto[1:0] == pkt.proto_code);
  assign sport_ok = (misc_rd.sport == '0) || (misc_rd.sport == pkt.source_port) ||
                    ((misc_rd.sport == fmpc_pkg::PORT_HIGH) &&
                     (pkt.source_port > fmpc_pkg::PORT_HIGH));
  assign dport_ok = (misc_rd.dport == '0) || (misc_rd.dport == pkt.dest_port) ||
                    ((misc_rd.dport == fmpc_pkg::PORT_HIGH) &&
                     (pkt.dest_port > fmpc_pkg::PORT_HIGH));
  assign pkt_ack_code = pkt.ack_flag ? fmpc_pkg::ACK_YES : fmpc_pkg::ACK_NO;
  assign ack_ok = (misc_rd.ack == fmpc_pkg::ACK_ANY) || (misc_rd.ack == pkt_ack_code);

  assign status.hit = dir_ok && sip_ok && dip_ok && proto_ok &&
                      ((pkt.proto_code == fmpc_pkg::PROTO_ICMP) ||
                       (sport_ok && dport_ok &&
                        ((pkt.proto_code == fmpc_pkg::PROTO_UDP) || ack_ok)));

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        fmpc_pkg::RES_PRE: begin
          res_verdict <= pre_verdict;
          res_reason  <= pre_reason;
          res_rule    <= '0;
          res_log     <= pre_log;
        end
        fmpc_pkg::RES_HIT: begin
          res_verdict <= misc_rd.action;
          res_reason  <= fmpc_pkg::REASON_MATCH;
          res_rule    <= fmpc_pkg::RULE_NUM_W'(idx_q);
          res_log     <= pkt.want_log;
        end
        default: begin
          res_verdict <= 1'b0;
          res_reason  <= fmpc_pkg::REASON_NO_MATCH;
          res_rule    <= '0;
          res_log     <= pkt.want_log;
        end
      endcase
    end
  end

  // Output register toward the result stream.
  always_comb begin
    out_pack              = '0;
    out_pack.verdict      = res_verdict;
    out_pack.reason       = res_reason;
    out_pack.matched_rule = res_rule;
    out_pack.log_request  = res_log;
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data <= out_pack;
    end
  end

endmodule

`default_nettype wire

/* rtl/first_match_packet_rule_classifier_core.sv */
// Top level of the first-match packet rule classifier.
//
// The input stream carries one request per transfer. tuser selects a rule word
// write or a packet classification. A write stores one 64-bit word of a rule and
// produces no result; the input stays ready for the next request.
// A classification produces exactly one result on the output stream.
// A classify request runs the special checks in the cycle after acceptance; if
// they do not decide and rules are active, it then scans the rule memory one
// rule per cycle from rule zero until the first hit or the last active rule.
// The result is loaded into a result register and then into the output
// register, and the input is ready again in the same cycle the result is
// presented. The input is not ready while a classification is in progress.
// The result sits in an output register; a stalled receiver holds it there
// and holds the block before its next result, but the next request is still
// taken. The configuration channel is always ready; it must be written only
// while the block idles, which the block does not enforce. Reset clears the
// rule count and the table-valid flag and loads the default leg addresses;
// the rule memory itself is undefined until written.
`default_nettype none

module first_match_packet_rule_classifier_core #(
  parameter int MAX_RULES = fmpc_pkg::MAX_RULES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // word_address, word_data, direction, source_ip, dest_ip, proto_code,
  // source_port, dest_port, ack_flag, xmas_flag, want_log, one zero pad bit
  input  wire logic [fmpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // func
  input  wire logic [0:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // verdict, reason, matched_rule, log_request, five zero pad bits
  output logic [fmpc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fmpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fmpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  fmpc_pkg::cmd_t    cmd;
  fmpc_pkg::status_t status;

  fmpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fmpc_datapath #(
    .MAX_RULES (MAX_RULES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
